/* hdl/sticksc_pkg.sv */
package sticksc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 12;
  localparam int THRESH_W         = 11;
  localparam int REPEAT_W         = 4;
  localparam int DIST_W           = 3;
  localparam int WHEEL_W          = 4;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 11;

  localparam logic [THRESH_W-1:0] DEAD_THRESHOLD_RST  = 11'd200;
  localparam logic [THRESH_W-1:0] FAST_THRESHOLD_RST  = 11'd900;
  localparam logic [REPEAT_W-1:0] REPEAT_INTERVAL_RST = 4'd6;
  localparam logic [DIST_W-1:0]   SLOW_DISTANCE_RST   = 3'd1;
  localparam logic [DIST_W-1:0]   FAST_DISTANCE_RST   = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_THRESHOLD  = 3'd0,
    REG_FAST_THRESHOLD  = 3'd1,
    REG_REPEAT_INTERVAL = 3'd2,
    REG_SLOW_DISTANCE   = 3'd3,
    REG_FAST_DISTANCE   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic neg;
    logic pos;
    logic fast;
  } zone_t;

endpackage

/* hdl/stick_scroll_autorepeat_top.sv */
// Channel  | Handshake           | Payload
// input    | in_valid, in_stall  | in_stick_vertical   (SAMPLE_WIDTH bit, signed)
// result   | out_valid, out_stall| out_wheel_distance  (4 bit, signed)
// config   | cfg_wr_en           | cfg_index, cfg_wdata
//
// One sample per cycle sustained unless out_stall holds the pipeline. The sample is
// registered, then zone compare and counter update feed the result register. Samples
// that cause no step produce no result transaction.
// Synchronous active-low reset clears held flags, counters and valids, and loads
// the config registers with their defaults.
// A stalled result holds the pipeline; in_stall rises only while both stages are full.
module stick_scroll_autorepeat_top #(
  parameter int SAMPLE_WIDTH = sticksc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_stick_vertical,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sticksc_pkg::WHEEL_W-1:0] out_wheel_distance,
  input  logic                                  cfg_wr_en,
  input  logic [sticksc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sticksc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import sticksc_pkg::*;

  logic [THRESH_W-1:0] dead_threshold_r;
  logic [THRESH_W-1:0] fast_threshold_r;
  logic [REPEAT_W-1:0] repeat_interval_r;
  logic [DIST_W-1:0]   slow_distance_r;
  logic [DIST_W-1:0]   fast_distance_r;

  logic                           s1_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample_r;
  logic                           out_valid_r;
  logic signed [WHEEL_W-1:0]      out_wheel_r;
  logic signed [WHEEL_W-1:0]      wheel_nxt;

  logic        s2_ready;
  logic        step_en;
  zone_t       zone;
  logic        neg_emit;
  logic        pos_emit;
  logic        neg_held;
  logic        pos_held;
  logic [DIST_W-1:0] mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_threshold_r  <= DEAD_THRESHOLD_RST;
      fast_threshold_r  <= FAST_THRESHOLD_RST;
      repeat_interval_r <= REPEAT_INTERVAL_RST;
      slow_distance_r   <= SLOW_DISTANCE_RST;
      fast_distance_r   <= FAST_DISTANCE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DEAD_THRESHOLD:  dead_threshold_r  <= cfg_wdata[THRESH_W-1:0];
        REG_FAST_THRESHOLD:  fast_threshold_r  <= cfg_wdata[THRESH_W-1:0];
        REG_REPEAT_INTERVAL: repeat_interval_r <= cfg_wdata[REPEAT_W-1:0];
        REG_SLOW_DISTANCE:   slow_distance_r   <= cfg_wdata[DIST_W-1:0];
        REG_FAST_DISTANCE:   fast_distance_r   <= cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign s2_ready = !out_valid_r || !out_stall;
  assign step_en  = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_sample_r <= in_stick_vertical;
    end
  end

  sticksc_classify #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_classify (
    .sample         (s1_sample_r),
    .dead_threshold (dead_threshold_r),
    .fast_threshold (fast_threshold_r),
    .zone           (zone)
  );

  sticksc_dir u_neg (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (step_en),
    .active          (zone.neg),
    .repeat_interval (repeat_interval_r),
    .emit            (neg_emit),
    .held            (neg_held)
  );

  sticksc_dir u_pos (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (step_en),
    .active          (zone.pos),
    .repeat_interval (repeat_interval_r),
    .emit            (pos_emit),
    .held            (pos_held)
  );

  always_comb begin
    mag = zone.fast ? fast_distance_r : slow_distance_r;
    if (neg_emit) begin
      wheel_nxt = -$signed({1'b0, mag});
    end else begin
      wheel_nxt = $signed({1'b0, mag});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= step_en && (neg_emit || pos_emit);
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && (neg_emit || pos_emit)) begin
      out_wheel_r <= wheel_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_wheel_distance = out_wheel_r;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a full pipeline");

  a_one_dir_emit: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |-> !(neg_emit && pos_emit))
    else $error("both directions emit on one sample");

  a_one_dir_held: assert property (@(posedge clk) disable iff (!rst_n)
    !(neg_held && pos_held))
    else $error("both directions held");

  a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(step_en))
    else $error("result appeared without a processed sample");

endmodule

/* hdl/sticksc_classify.sv */
module sticksc_classify #(
  parameter int SAMPLE_WIDTH = sticksc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic signed [SAMPLE_WIDTH-1:0]     sample,
  input  logic [sticksc_pkg::THRESH_W-1:0]   dead_threshold,
  input  logic [sticksc_pkg::THRESH_W-1:0]   fast_threshold,
  output sticksc_pkg::zone_t                 zone
);
  import sticksc_pkg::*;

  localparam int CMP_W = ((SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W) + 2;

  logic signed [CMP_W-1:0] v_ext;
  logic signed [CMP_W-1:0] dead_ext;
  logic signed [CMP_W-1:0] fast_ext;
  logic                    neg_fast;
  logic                    neg_dead;
  logic                    pos_fast;
  logic                    pos_dead;

  always_comb begin
    v_ext    = CMP_W'(sample);
    dead_ext = $signed(CMP_W'(dead_threshold));
    fast_ext = $signed(CMP_W'(fast_threshold));
    neg_fast = v_ext < -fast_ext;
    neg_dead = v_ext < -dead_ext;
    pos_fast = v_ext > fast_ext;
    pos_dead = v_ext > dead_ext;
    zone.neg  = neg_fast || neg_dead;
    zone.pos  = pos_fast || pos_dead;
    zone.fast = neg_fast || pos_fast;
  end

endmodule

/* hdl/sticksc_dir.sv */
module sticksc_dir (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step_en,
  input  logic                             active,
  input  logic [sticksc_pkg::REPEAT_W-1:0] repeat_interval,
  output logic                             emit,
  output logic                             held
);
  import sticksc_pkg::*;

  logic                held_r;
  logic                held_nxt;
  logic [REPEAT_W-1:0] count_r;
  logic [REPEAT_W-1:0] count_nxt;
  logic                expired;

  always_comb begin
    expired   = count_r <= REPEAT_W'(1);
    emit      = active && (!held_r || expired);
    held_nxt  = active;
    count_nxt = count_r;
    if (active) begin
      if (!held_r || expired) begin
        count_nxt = repeat_interval;
      end else begin
        count_nxt = count_r - REPEAT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      count_r <= '0;
    end else if (step_en) begin
      held_r  <= held_nxt;
      count_r <= count_nxt;
    end
  end

  assign held = held_r;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import sticksc_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int SAMPLE_MAX = (1 << (SW - 1)) - 1;
  localparam int SAMPLE_MIN = -(1 << (SW - 1));
  localparam int DIR_NEG = 0;
  localparam int DIR_POS = 1;
  localparam int PHASES = 11;
  localparam int PHASE_ITEMS = 150;

  typedef enum int {
    Z_NEUTRAL,
    Z_WEAK_NEG,
    Z_STRONG_NEG,
    Z_WEAK_POS,
    Z_STRONG_POS
  } zone_pick_t;

  class scroll_scoreboard;
    logic [THRESH_W-1:0] dead_thr;
    logic [THRESH_W-1:0] fast_thr;
    logic [REPEAT_W-1:0] rep;
    logic [DIST_W-1:0]   slow_d;
    logic [DIST_W-1:0]   fast_d;
    bit                  held[2];
    logic [REPEAT_W-1:0] countdown[2];
    logic signed [WHEEL_W-1:0] pending_steps[$];
    int samples;
    int steps;
    int errors;

    function new();
      dead_thr = DEAD_THRESHOLD_RST;
      fast_thr = FAST_THRESHOLD_RST;
      rep = REPEAT_INTERVAL_RST;
      slow_d = SLOW_DISTANCE_RST;
      fast_d = FAST_DISTANCE_RST;
      held[DIR_NEG] = 1'b0;
      held[DIR_POS] = 1'b0;
      countdown[DIR_NEG] = '0;
      countdown[DIR_POS] = '0;
      samples = 0;
      steps = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DEAD_THRESHOLD:  dead_thr = data[THRESH_W-1:0];
        REG_FAST_THRESHOLD:  fast_thr = data[THRESH_W-1:0];
        REG_REPEAT_INTERVAL: rep = data[REPEAT_W-1:0];
        REG_SLOW_DISTANCE:   slow_d = data[DIST_W-1:0];
        REG_FAST_DISTANCE:   fast_d = data[DIST_W-1:0];
        default: ;
      endcase
    endfunction

    function bit advance(int d, bit active);
      if (!active) begin
        held[d] = 1'b0;
        return 1'b0;
      end
      if (!held[d]) begin
        held[d] = 1'b1;
        countdown[d] = rep;
        return 1'b1;
      end
      if (countdown[d] <= 1) begin
        countdown[d] = rep;
        return 1'b1;
      end
      countdown[d] = countdown[d] - 1'b1;
      return 1'b0;
    endfunction

    function void note_sample(logic signed [SW-1:0] v);
      int s;
      int dead;
      int fast;
      bit neg;
      bit pos;
      bit hard;
      bit emit_neg;
      bit emit_pos;
      logic [WHEEL_W-1:0] mag;
      s = v;
      dead = dead_thr;
      fast = fast_thr;
      neg = 1'b0;
      pos = 1'b0;
      hard = 1'b0;
      if (s < -fast) begin
        neg = 1'b1;
        hard = 1'b1;
      end else if (s < -dead) begin
        neg = 1'b1;
      end
      if (s > fast) begin
        pos = 1'b1;
        hard = 1'b1;
      end else if (s > dead) begin
        pos = 1'b1;
      end
      emit_neg = advance(DIR_NEG, neg);
      emit_pos = advance(DIR_POS, pos);
      mag = {1'b0, (hard ? fast_d : slow_d)};
      samples++;
      if (emit_neg) pending_steps.push_back(WHEEL_W'(0) - mag);
      else if (emit_pos) pending_steps.push_back(mag);
    endfunction

    function void check_step(logic signed [WHEEL_W-1:0] actual);
      logic signed [WHEEL_W-1:0] expected;
      if (pending_steps.size() == 0) begin
        $display("%0t: wheel_distance expected none, actual %0d", $time, actual);
        errors++;
        return;
      end
      expected = pending_steps.pop_front();
      steps++;
      if (actual !== expected) begin
        $display("%0t: wheel_distance expected %0d, actual %0d", $time, expected, actual);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SW-1:0] in_stick_vertical = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [WHEEL_W-1:0] out_wheel_distance;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int settings = 0;
  scroll_scoreboard sb = new();

  stick_scroll_autorepeat_top #(.SAMPLE_WIDTH(SW)) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_stick_vertical  (in_stick_vertical),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_wheel_distance (out_wheel_distance),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_step(out_wheel_distance);
  end

  task automatic send_sample(input int v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_stick_vertical <= SW'(v);
    do @(posedge clk); while (in_stall);
    sb.note_sample(SW'(v));
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (sb.pending_steps.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_setting(input int dead, input int fast, input int rep,
                               input int slow, input int fastd);
    write_reg(REG_DEAD_THRESHOLD, CFG_DATA_W'(dead));
    write_reg(REG_FAST_THRESHOLD, CFG_DATA_W'(fast));
    write_reg(REG_REPEAT_INTERVAL, {(CFG_DATA_W - REPEAT_W)'($urandom), REPEAT_W'(rep)});
    write_reg(REG_SLOW_DISTANCE, {(CFG_DATA_W - DIST_W)'($urandom), DIST_W'(slow)});
    write_reg(REG_FAST_DISTANCE, {(CFG_DATA_W - DIST_W)'($urandom), DIST_W'(fastd)});
    // unmapped index: must leave every register alone
    write_reg(CFG_IDX_W'(REG_FAST_DISTANCE + 1 + $urandom_range(2)), CFG_DATA_W'($urandom));
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  function automatic int zone_sample(zone_pick_t z);
    int dead;
    int fast;
    int lo;
    int hi;
    dead = sb.dead_thr;
    fast = sb.fast_thr;
    case (z)
      Z_NEUTRAL: begin
        hi = (dead < fast) ? dead : fast;
        lo = -hi;
      end
      Z_WEAK_POS: begin
        lo = dead + 1;
        hi = fast;
      end
      Z_STRONG_POS: begin
        lo = fast + 1;
        hi = SAMPLE_MAX;
      end
      Z_WEAK_NEG: begin
        lo = -fast;
        hi = -dead - 1;
      end
      default: begin
        lo = SAMPLE_MIN;
        hi = -fast - 1;
      end
    endcase
    if (hi < lo) return SAMPLE_MIN + int'($urandom_range(SAMPLE_MAX - SAMPLE_MIN));
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic run_random(input int count);
    int sent;
    int len;
    zone_pick_t z;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 80) begin
        z = zone_pick_t'(Z_WEAK_NEG + $urandom_range(3));
        len = 1 + $urandom_range(2 * sb.rep + 3);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(9) == 0) begin
            case (z)
              Z_WEAK_NEG:   z = Z_STRONG_NEG;
              Z_STRONG_NEG: z = Z_WEAK_NEG;
              Z_WEAK_POS:   z = Z_STRONG_POS;
              default:      z = Z_WEAK_POS;
            endcase
          end
          send_sample(zone_sample(z));
          sent++;
        end
      end else begin
        len = 1 + $urandom_range(3);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(1) == 0) send_sample(zone_sample(Z_NEUTRAL));
          else send_sample(SAMPLE_MIN + int'($urandom_range(SAMPLE_MAX - SAMPLE_MIN)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int directed[$];
    directed = '{0, 200, 201, 900, 901, 901, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX,
                 -201, -200, -901, -900, 500, 500, 500, 500, 500, 500, 500,
                 -SAMPLE_MAX, 0, -1, 1};
    send_idle_pct = 8;
    recv_idle_pct = 72;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values first
    foreach (directed[i]) send_sample(directed[i]);

    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      if (p == 4) begin
        send_idle_pct = 72;
        recv_idle_pct = 8;
      end else if (p == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: apply_setting(0, 2047, 15, 7, 1);
        1: apply_setting(2047, 0, 1, 1, 7);
        2: apply_setting(900, 200, 0, 0, 0);
        default: apply_setting($urandom_range(1500), $urandom_range(2047), $urandom_range(15),
                               $urandom_range(7), $urandom_range(7));
      endcase
      run_random(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    while (sb.pending_steps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d stick samples and %0d wheel steps over %0d register settings",
             sb.samples, sb.steps, settings + 1);
    if (sb.errors == 0 && sb.pending_steps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
